// ===== rtl/btff_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btff_pkg
// Shared constants and types for the boundary-tag first-fit allocator.
// ----------------------------------------------------------------------------
package btff_pkg;

    localparam int AREA_BYTES      = 256;
    localparam int ADDR_W          = $clog2(AREA_BYTES);
    localparam int SPLIT_MIN_BYTES = 6;
    localparam int TAG_BYTES       = 4;
    localparam int HDR_BYTES       = 2;
    localparam int MAX_REQ         = AREA_BYTES - TAG_BYTES;
    localparam int MID_SIZE        = AREA_BYTES - 12;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [7:0]        byte_t;

    localparam byte_t TAG_FREE = 8'd0;
    localparam byte_t TAG_USED = 8'd1;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef struct packed {
        logic  en;
        addr_t addr;
        byte_t data;
    } mem_wr_t;

    typedef struct packed {
        logic  valid;
        logic  granted;
        byte_t offset;
    } res_t;

endpackage

// ===== rtl/boundary_tag_first_fit_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boundary_tag_first_fit_allocator
// Boundary-tag first-fit allocator over a 256-byte arena held in one RAM.
// ----------------------------------------------------------------------------
// allocate: per block walked a status read, a size read and a check, then 2 or 7
//   tag writes one per cycle, then S_DONE; an oversized request goes straight to S_DONE
// release: one extra step per merge side; results wait in S_DONE for a free m_tdata
// one word in flight; s_tready returns in the same cycle the result is loaded, and
//   the next word is taken while that result waits in m_tdata
// reset: a pass over every arena byte loads the arena image, s_tready stays low until done
// ----------------------------------------------------------------------------
module boundary_tag_first_fit_allocator
    import btff_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // request_size, user_offset
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // payload_offset
    output logic        m_tuser    // granted
);

    mem_wr_t init_wr;
    mem_wr_t seq_wr;
    mem_wr_t ram_wr;
    res_t    res;
    logic    init_done;
    logic    seq_idle;
    logic    out_free;
    addr_t   rd_addr;
    byte_t   rd_data;

    logic    m_tvalid_reg;
    byte_t   m_tdata_reg;
    logic    m_tuser_reg;

    assign s_tready = init_done && seq_idle;
    assign out_free = !m_tvalid_reg || m_tready;
    assign ram_wr   = init_done ? seq_wr : init_wr;

    btff_init u_init (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (init_wr),
        .done    (init_done)
    );

    btff_ram #(
        .WIDTH (8),
        .DEPTH (AREA_BYTES)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr.en),
        .wr_addr (ram_wr.addr),
        .wr_data (ram_wr.data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    btff_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_tvalid && s_tready),
        .op       (s_tuser),
        .req      (s_tdata[7:0]),
        .uoff     (s_tdata[15:8]),
        .out_free (out_free),
        .rd_data  (rd_data),
        .rd_addr  (rd_addr),
        .wr       (seq_wr),
        .res      (res),
        .idle     (seq_idle)
    );

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res.valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (res.valid) begin
            m_tdata_reg <= res.offset;
            m_tuser_reg <= res.granted;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== rtl/btff_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btff_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module btff_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/btff_init.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btff_init
// Post-reset pass that loads the arena with two sentinels and one free block.
// ----------------------------------------------------------------------------
module btff_init
    import btff_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    output mem_wr_t wr,
    output logic    done
);

    logic [ADDR_W:0] cnt_reg;
    logic [ADDR_W:0] cnt_next;

    function automatic byte_t reset_byte(input addr_t a);
        byte_t v;
        v = TAG_FREE;
        priority if (a == addr_t'(0) || a == addr_t'(3)) begin
            v = TAG_USED;
        end else if (a == addr_t'(AREA_BYTES - 4) || a == addr_t'(AREA_BYTES - 1)) begin
            v = TAG_USED;
        end else if (a == addr_t'(5) || a == addr_t'(AREA_BYTES - 6)) begin
            v = byte_t'(MID_SIZE);
        end else begin
            v = TAG_FREE;
        end
        return v;
    endfunction

    assign done     = (cnt_reg == (ADDR_W+1)'(AREA_BYTES));
    assign cnt_next = cnt_reg + (ADDR_W+1)'(1);

    always_comb begin
        wr.en   = !done;
        wr.addr = cnt_reg[ADDR_W-1:0];
        wr.data = reset_byte(cnt_reg[ADDR_W-1:0]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (!done) begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== rtl/btff_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btff_seq
// Read-modify-write sequencer: first-fit walk with split, release with merge.
// ----------------------------------------------------------------------------
module btff_seq
    import btff_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    start,
    input  logic    op,
    input  byte_t   req,
    input  byte_t   uoff,
    input  logic    out_free,
    input  byte_t   rd_data,
    output addr_t   rd_addr,
    output mem_wr_t wr,
    output res_t    res,
    output logic    idle
);

    localparam int BLK_W  = ADDR_W + 2;
    localparam int STEP_W = 3;

    typedef enum logic [4:0] {
        S_IDLE, S_AHDR, S_ASIZE, S_ACHK, S_AWR,
        S_RSIZE, S_RCLR0, S_RCLR1, S_RLSTAT, S_RLCHK, S_RLSIZE,
        S_RRSTAT, S_RRCHK, S_RRSIZE, S_RWSZ0, S_RWSZ1, S_DONE
    } state_t;

    state_t            state_reg;
    logic [BLK_W-1:0]  blk_reg;
    byte_t             req_reg;
    byte_t             sz_reg;
    byte_t             stat_reg;
    logic              whole_reg;
    logic [STEP_W-1:0] step_reg;
    logic              op_reg;
    logic              granted_reg;
    byte_t             offset_reg;

    addr_t             blk_a;
    byte_t             rest;
    logic [BLK_W-1:0]  blk_next;
    logic [STEP_W-1:0] last_step;

    assign blk_a     = blk_reg[ADDR_W-1:0];
    assign rest      = sz_reg - req_reg - byte_t'(TAG_BYTES);
    assign blk_next  = blk_reg + BLK_W'(rd_data) + BLK_W'(TAG_BYTES);
    assign last_step = whole_reg ? STEP_W'(1) : STEP_W'(6);
    assign idle      = (state_reg == S_IDLE);

    // read address per state; sz_reg holds the current block size on release
    always_comb begin
        unique case (state_reg)
            S_AHDR:   rd_addr = blk_a;
            S_ASIZE:  rd_addr = blk_a + addr_t'(1);
            S_RSIZE:  rd_addr = blk_a + addr_t'(1);
            S_RLSTAT: rd_addr = blk_a - addr_t'(1);
            S_RLCHK:  rd_addr = blk_a - addr_t'(2);
            S_RRSTAT: rd_addr = blk_a + addr_t'(sz_reg) + addr_t'(4);
            S_RRCHK:  rd_addr = blk_a + addr_t'(sz_reg) + addr_t'(5);
            default:  rd_addr = blk_a;
        endcase
    end

    // writes go out one per cycle in the same order as the algorithm
    always_comb begin
        wr.en   = 1'b0;
        wr.addr = blk_a;
        wr.data = TAG_FREE;
        unique case (state_reg)
            S_AWR: begin
                wr.en = 1'b1;
                if (whole_reg) begin
                    wr.data = TAG_USED;
                    wr.addr = (step_reg == '0) ? blk_a
                                               : blk_a + addr_t'(sz_reg) + addr_t'(3);
                end else begin
                    unique case (step_reg)
                        3'd0: begin
                            wr.addr = blk_a + addr_t'(sz_reg) + addr_t'(2);
                            wr.data = rest;
                        end
                        3'd1: begin
                            wr.addr = blk_a;
                            wr.data = TAG_USED;
                        end
                        3'd2: begin
                            wr.addr = blk_a + addr_t'(1);
                            wr.data = req_reg;
                        end
                        3'd3: begin
                            wr.addr = blk_a + addr_t'(req_reg) + addr_t'(2);
                            wr.data = req_reg;
                        end
                        3'd4: begin
                            wr.addr = blk_a + addr_t'(req_reg) + addr_t'(3);
                            wr.data = TAG_USED;
                        end
                        3'd5: begin
                            wr.addr = blk_a + addr_t'(req_reg) + addr_t'(4);
                            wr.data = TAG_FREE;
                        end
                        default: begin
                            wr.addr = blk_a + addr_t'(req_reg) + addr_t'(5);
                            wr.data = rest;
                        end
                    endcase
                end
            end
            S_RCLR0: begin
                wr.en   = 1'b1;
                wr.addr = blk_a;
                wr.data = TAG_FREE;
            end
            S_RCLR1: begin
                wr.en   = 1'b1;
                wr.addr = blk_a + addr_t'(sz_reg) + addr_t'(3);
                wr.data = TAG_FREE;
            end
            S_RWSZ0: begin
                wr.en   = 1'b1;
                wr.addr = blk_a + addr_t'(1);
                wr.data = sz_reg;
            end
            S_RWSZ1: begin
                wr.en   = 1'b1;
                wr.addr = blk_a + addr_t'(sz_reg) + addr_t'(2);
                wr.data = sz_reg;
            end
            default: wr.en = 1'b0;
        endcase
    end

    always_comb begin
        res.valid   = (state_reg == S_DONE) && out_free;
        res.granted = granted_reg;
        res.offset  = offset_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            step_reg    <= '0;
            op_reg      <= OP_ALLOC;
            granted_reg <= 1'b0;
            offset_reg  <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        op_reg  <= op;
                        req_reg <= req;
                        if (op == OP_RELEASE) begin
                            blk_reg   <= BLK_W'(uoff - byte_t'(HDR_BYTES));
                            state_reg <= S_RSIZE;
                        end else if ({1'b0, req} > (ADDR_W+1)'(MAX_REQ)) begin
                            granted_reg <= 1'b0;
                            offset_reg  <= '0;
                            state_reg   <= S_DONE;
                        end else begin
                            blk_reg   <= '0;
                            state_reg <= S_AHDR;
                        end
                    end
                end
                S_AHDR:  state_reg <= S_ASIZE;
                S_ASIZE: begin
                    stat_reg  <= rd_data;
                    state_reg <= S_ACHK;
                end
                S_ACHK: begin
                    if (stat_reg == TAG_FREE && rd_data >= req_reg) begin
                        sz_reg    <= rd_data;
                        whole_reg <= (rd_data - req_reg) < byte_t'(SPLIT_MIN_BYTES);
                        step_reg  <= '0;
                        state_reg <= S_AWR;
                    end else if (blk_next >= BLK_W'(AREA_BYTES)) begin
                        granted_reg <= 1'b0;
                        offset_reg  <= '0;
                        state_reg   <= S_DONE;
                    end else begin
                        blk_reg   <= blk_next;
                        state_reg <= S_AHDR;
                    end
                end
                S_AWR: begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == last_step) begin
                        granted_reg <= 1'b1;
                        offset_reg  <= byte_t'(blk_a + addr_t'(HDR_BYTES));
                        state_reg   <= S_DONE;
                    end
                end
                S_RSIZE: state_reg <= S_RCLR0;
                S_RCLR0: begin
                    sz_reg    <= rd_data;
                    state_reg <= S_RCLR1;
                end
                S_RCLR1:  state_reg <= S_RLSTAT;
                S_RLSTAT: state_reg <= S_RLCHK;
                S_RLCHK:  state_reg <= (rd_data == TAG_FREE) ? S_RLSIZE : S_RRSTAT;
                S_RLSIZE: begin
                    // absorb the left neighbour, tags included
                    sz_reg    <= sz_reg + rd_data + byte_t'(TAG_BYTES);
                    blk_reg   <= BLK_W'(blk_a - addr_t'(rd_data) - addr_t'(4));
                    state_reg <= S_RRSTAT;
                end
                S_RRSTAT: state_reg <= S_RRCHK;
                S_RRCHK:  state_reg <= (rd_data == TAG_FREE) ? S_RRSIZE : S_RWSZ0;
                S_RRSIZE: begin
                    sz_reg    <= sz_reg + rd_data + byte_t'(TAG_BYTES);
                    state_reg <= S_RWSZ0;
                end
                S_RWSZ0: state_reg <= S_RWSZ1;
                S_RWSZ1: begin
                    granted_reg <= 1'b1;
                    offset_reg  <= '0;
                    state_reg   <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_walk_in_arena: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_AHDR) |-> (blk_reg < BLK_W'(AREA_BYTES)))
        else $error("walk header beyond arena");

    a_release_granted: assert property (@(posedge aclk) disable iff (!aresetn)
        (res.valid && op_reg == OP_RELEASE) |-> (res.granted && res.offset == '0))
        else $error("release result not granted with zero offset");

    a_result_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |=> (state_reg == S_IDLE))
        else $error("sequencer did not return to idle after result");

    a_whole_two_writes: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_AWR && whole_reg) |-> (step_reg <= STEP_W'(1)))
        else $error("whole grant wrote more than two tags");

    a_fail_offset_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (res.valid && !res.granted) |-> (res.offset == '0))
        else $error("failed allocate with nonzero offset");

endmodule
